// ===== design/bba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and codes of the bitmap block allocator: command, pool and
// status codes, register map, configuration bundle, memory request and the
// sequencer state type.
// ----------------------------------------------------------------------------
package bba_pkg;

    // Bitmap word geometry
    localparam int WORD_W    = 32;
    localparam int BIT_SEL_W = 5;
    // Widest word address of either bitmap (65536 bits / 32)
    localparam int MEM_AW_W  = 11;

    // Command codes
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_CLEAR = 2'd2;

    // Pool select
    localparam logic POOL_INODE = 1'b0;
    localparam logic POOL_DATA  = 1'b1;

    // Response status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;

    // Register map (word index into the APB space)
    localparam int         PADDR_W         = 4;
    localparam logic [1:0] REG_INODE_LIMIT = 2'd0;
    localparam logic [1:0] REG_DATA_BASE   = 2'd1;
    localparam logic [1:0] REG_TOTAL_BLKS  = 2'd2;

    // Register reset values
    localparam logic [10:0] INODE_LIMIT_RST = 11'd1024;
    localparam logic [31:0] DATA_BASE_RST   = 32'd36;
    localparam logic [31:0] TOTAL_BLKS_RST  = 32'd64;

    typedef struct packed {
        logic [10:0] inode_limit;
        logic [31:0] data_base;
        logic [31:0] blk_total;
    } cfg_t;

    // Single-port bitmap memory request
    typedef struct packed {
        logic                en;
        logic                we;
        logic [MEM_AW_W-1:0] addr;
        logic [WORD_W-1:0]   wdata;
    } mem_req_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_PREP,
        S_SCAN,
        S_FREE_CHK,
        S_FREE_WR,
        S_CLEAR,
        S_DONE
    } state_t;

endpackage

// ===== design/bba_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_req_if
// Request channel: command, pool and index with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic        pool;
    logic [31:0] index;

    modport source (output valid, output cmd, output pool, output index, input ready);
    modport sink   (input valid, input cmd, input pool, input index, output ready);
endinterface

// ===== design/bba_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_rsp_if
// Response channel: status and granted number with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface bba_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted;

    modport source (output valid, output status, output granted, input ready);
    modport sink   (input valid, input status, input granted, output ready);
endinterface

// ===== design/bba_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_regs
// APB configuration registers: inode limit, data base and total blocks.
// ----------------------------------------------------------------------------
module bba_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output bba_pkg::cfg_t                cfg
);

    bba_pkg::cfg_t cfg_reg;
    bba_pkg::cfg_t cfg_next;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_sel)
                bba_pkg::REG_INODE_LIMIT: cfg_next.inode_limit = pwdata[10:0];
                bba_pkg::REG_DATA_BASE:   cfg_next.data_base   = pwdata;
                bba_pkg::REG_TOTAL_BLKS:  cfg_next.blk_total   = pwdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    // Read mux
    always_comb
    begin
        unique case (reg_sel)
            bba_pkg::REG_INODE_LIMIT: prdata = {21'd0, cfg_reg.inode_limit};
            bba_pkg::REG_DATA_BASE:   prdata = cfg_reg.data_base;
            bba_pkg::REG_TOTAL_BLKS:  prdata = cfg_reg.blk_total;
            default:                  prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.inode_limit <= bba_pkg::INODE_LIMIT_RST;
            cfg_reg.data_base   <= bba_pkg::DATA_BASE_RST;
            cfg_reg.blk_total   <= bba_pkg::TOTAL_BLKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/bba_bitmap_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_bitmap_ram
// Single-port synchronous bitmap memory, 32-bit words, registered read.
// ----------------------------------------------------------------------------
module bba_bitmap_ram #(
    parameter int DEPTH = 32
) (
    input  logic                         clk,
    input  bba_pkg::mem_req_t            req,
    output logic [bba_pkg::WORD_W-1:0]   rdata
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [bba_pkg::WORD_W-1:0] mem [DEPTH];
    logic [bba_pkg::WORD_W-1:0] rdata_reg;

    assign rdata = rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[req.addr[AW-1:0]] <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem[req.addr[AW-1:0]];
            end
        end
    end

endmodule

// ===== design/bba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bba_ctrl
// Allocator sequencer: word scan with pipelined reads for allocate,
// read-modify-write for free, clearing sweeps, and the response register.
// ----------------------------------------------------------------------------
module bba_ctrl #(
    parameter int INODE_BITS = 1024,
    parameter int DATA_BITS  = 4096
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bba_pkg::cfg_t               cfg,
    bba_req_if.sink                     req,
    bba_rsp_if.source                   rsp,
    output bba_pkg::mem_req_t           inode_mem,
    output bba_pkg::mem_req_t           data_mem,
    input  logic [bba_pkg::WORD_W-1:0]  inode_rdata,
    input  logic [bba_pkg::WORD_W-1:0]  data_rdata
);

    localparam int IWORDS = (INODE_BITS + 31) / 32;
    localparam int DWORDS = (DATA_BITS + 31) / 32;
    localparam int MWORDS = (IWORDS > DWORDS) ? IWORDS : DWORDS;
    localparam int MAXB   = (INODE_BITS > DATA_BITS) ? INODE_BITS : DATA_BITS;
    localparam int PW     = $clog2(MWORDS + 1);
    localparam int NW     = $clog2(MAXB + 1);

    // Lowest set bit of a word
    function automatic logic [bba_pkg::BIT_SEL_W-1:0] lowest_bit(input logic [31:0] w);
        logic [bba_pkg::BIT_SEL_W-1:0] pos;
        pos = '0;
        for (int k = 31; k >= 0; k--)
        begin
            if (w[k])
            begin
                pos = bba_pkg::BIT_SEL_W'(k);
            end
        end
        return pos;
    endfunction

    bba_pkg::state_t state_reg, state_next;
    logic [1:0]      cmd_reg, cmd_next;
    logic            pool_reg, pool_next;
    logic [31:0]     idx_reg, idx_next;
    logic [NW-1:0]   span_reg, span_next;
    logic [31:0]     off_reg, off_next;
    logic            bad_reg, bad_next;
    logic [PW-1:0]   ptr_reg, ptr_next;
    logic            chk_vld_reg, chk_vld_next;
    logic [PW-1:0]   chk_ptr_reg, chk_ptr_next;
    logic [1:0]      res_status_reg, res_status_next;
    logic            res_grant_reg, res_grant_next;
    logic            rsp_vld_reg, rsp_vld_next;
    logic [1:0]      rsp_status_reg, rsp_status_next;
    logic [31:0]     rsp_granted_reg, rsp_granted_next;

    logic                          req_fire;
    logic [31:0]                   rdata;
    logic [31:0]                   diff_c;
    logic [NW-1:0]                 inode_span_c;
    logic [NW-1:0]                 data_span_c;
    logic [PW-1:0]                 scan_words;
    logic                          issue;
    logic [NW-6:0]                 limit_word;
    logic [4:0]                    limit_bit;
    logic [31:0]                   word_mask;
    logic [31:0]                   free_bits;
    logic                          found;
    logic                          scan_done;
    logic [bba_pkg::BIT_SEL_W-1:0] hit_bit;
    logic                          range_bad;
    logic [PW-1:0]                 pool_last;
    logic                          clear_last;
    logic                          init_last;
    logic [31:0]                   free_mask;
    logic                          done_take;
    logic [31:0]                   base_sum;
    bba_pkg::mem_req_t             act_mem;
    bba_pkg::mem_req_t             idle_mem;

    assign req_fire = req.valid && req.ready;
    assign rdata    = (pool_reg == bba_pkg::POOL_DATA) ? data_rdata : inode_rdata;

    // Pool sizes from configuration
    assign diff_c       = cfg.blk_total - cfg.data_base;
    assign inode_span_c = (32'(cfg.inode_limit) < 32'(INODE_BITS)) ?
                          NW'(cfg.inode_limit) : NW'(INODE_BITS);
    assign data_span_c  = (cfg.blk_total <= cfg.data_base) ? '0 :
                          (diff_c < 32'(DATA_BITS)) ? NW'(diff_c) : NW'(DATA_BITS);

    // Scan window: words holding any bit below the span
    assign scan_words = PW'((32'(span_reg) + 32'd31) >> 5);
    assign issue      = ptr_reg < scan_words;
    assign limit_word = span_reg[NW-1:5];
    assign limit_bit  = span_reg[4:0];

    // Valid-bit mask of the word under check
    always_comb
    begin
        if (32'(chk_ptr_reg) < 32'(limit_word))
        begin
            word_mask = '1;
        end
        else if (32'(chk_ptr_reg) == 32'(limit_word))
        begin
            word_mask = (32'd1 << limit_bit) - 32'd1;
        end
        else
        begin
            word_mask = '0;
        end
        // Inode number zero is reserved
        if ((pool_reg == bba_pkg::POOL_INODE) && (chk_ptr_reg == '0))
        begin
            word_mask[0] = 1'b0;
        end
    end

    assign free_bits  = ~rdata & word_mask;
    assign found      = chk_vld_reg && (|free_bits);
    assign scan_done  = !issue && !found;
    assign hit_bit    = lowest_bit(free_bits);
    assign range_bad  = bad_reg || (off_reg >= 32'(span_reg));
    assign pool_last  = (pool_reg == bba_pkg::POOL_DATA) ? PW'(DWORDS - 1) : PW'(IWORDS - 1);
    assign clear_last = ptr_reg == pool_last;
    assign init_last  = ptr_reg == PW'(MWORDS - 1);
    assign free_mask  = 32'd1 << off_reg[4:0];
    assign done_take  = !rsp_vld_reg || rsp.ready;
    assign base_sum   = cfg.data_base + off_reg;

    assign rsp.valid   = rsp_vld_reg;
    assign rsp.status  = rsp_status_reg;
    assign rsp.granted = rsp_granted_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bba_pkg::S_INIT:     if (init_last) state_next = bba_pkg::S_IDLE;
            bba_pkg::S_IDLE:     if (req_fire) state_next = bba_pkg::S_PREP;
            bba_pkg::S_PREP:
            begin
                unique case (cmd_reg)
                    bba_pkg::CMD_ALLOC: state_next = bba_pkg::S_SCAN;
                    bba_pkg::CMD_FREE:  state_next = bba_pkg::S_FREE_CHK;
                    bba_pkg::CMD_CLEAR: state_next = bba_pkg::S_CLEAR;
                    default:            state_next = bba_pkg::S_DONE;
                endcase
            end
            bba_pkg::S_SCAN:     if (found || scan_done) state_next = bba_pkg::S_DONE;
            bba_pkg::S_FREE_CHK: state_next = range_bad ? bba_pkg::S_DONE : bba_pkg::S_FREE_WR;
            bba_pkg::S_FREE_WR:  state_next = bba_pkg::S_DONE;
            bba_pkg::S_CLEAR:    if (clear_last) state_next = bba_pkg::S_DONE;
            bba_pkg::S_DONE:     if (done_take) state_next = bba_pkg::S_IDLE;
            default:             state_next = bba_pkg::S_INIT;
        endcase
    end

    // Outputs: handshake and memory requests
    always_comb
    begin
        idle_mem  = '0;
        act_mem   = '0;
        inode_mem = '0;
        data_mem  = '0;
        req.ready = (state_reg == bba_pkg::S_IDLE);
        unique case (state_reg)
            bba_pkg::S_INIT:
            begin
                // Reset sweep clears both bitmaps together
                inode_mem.en   = ptr_reg < PW'(IWORDS);
                inode_mem.we   = 1'b1;
                inode_mem.addr = bba_pkg::MEM_AW_W'(ptr_reg);
                data_mem.en    = ptr_reg < PW'(DWORDS);
                data_mem.we    = 1'b1;
                data_mem.addr  = bba_pkg::MEM_AW_W'(ptr_reg);
            end
            bba_pkg::S_SCAN:
            begin
                if (found)
                begin
                    act_mem.en    = 1'b1;
                    act_mem.we    = 1'b1;
                    act_mem.addr  = bba_pkg::MEM_AW_W'(chk_ptr_reg);
                    act_mem.wdata = rdata | (32'd1 << hit_bit);
                end
                else if (issue)
                begin
                    act_mem.en   = 1'b1;
                    act_mem.addr = bba_pkg::MEM_AW_W'(ptr_reg);
                end
            end
            bba_pkg::S_FREE_CHK:
            begin
                act_mem.en   = !range_bad;
                act_mem.addr = bba_pkg::MEM_AW_W'(off_reg >> 5);
            end
            bba_pkg::S_FREE_WR:
            begin
                act_mem.en    = 1'b1;
                act_mem.we    = 1'b1;
                act_mem.addr  = bba_pkg::MEM_AW_W'(off_reg >> 5);
                act_mem.wdata = rdata & ~free_mask;
            end
            bba_pkg::S_CLEAR:
            begin
                act_mem.en   = 1'b1;
                act_mem.we   = 1'b1;
                act_mem.addr = bba_pkg::MEM_AW_W'(ptr_reg);
            end
            default:
            begin
                act_mem = idle_mem;
            end
        endcase
        // Steer the active request to the selected pool
        if (state_reg != bba_pkg::S_INIT)
        begin
            inode_mem = (pool_reg == bba_pkg::POOL_INODE) ? act_mem : idle_mem;
            data_mem  = (pool_reg == bba_pkg::POOL_DATA)  ? act_mem : idle_mem;
        end
    end

    // Datapath next values
    always_comb
    begin
        cmd_next         = cmd_reg;
        pool_next        = pool_reg;
        idx_next         = idx_reg;
        span_next        = span_reg;
        off_next         = off_reg;
        bad_next         = bad_reg;
        ptr_next         = ptr_reg;
        chk_vld_next     = chk_vld_reg;
        chk_ptr_next     = chk_ptr_reg;
        res_status_next  = res_status_reg;
        res_grant_next   = res_grant_reg;
        rsp_vld_next     = rsp_vld_reg && !rsp.ready;
        rsp_status_next  = rsp_status_reg;
        rsp_granted_next = rsp_granted_reg;
        unique case (state_reg)
            bba_pkg::S_INIT:
            begin
                ptr_next = init_last ? '0 : ptr_reg + PW'(1);
            end
            bba_pkg::S_IDLE:
            begin
                if (req_fire)
                begin
                    cmd_next  = req.cmd;
                    pool_next = req.pool;
                    idx_next  = req.index;
                end
            end
            bba_pkg::S_PREP:
            begin
                if (pool_reg == bba_pkg::POOL_DATA)
                begin
                    span_next = data_span_c;
                    off_next  = idx_reg - cfg.data_base;
                    bad_next  = idx_reg < cfg.data_base;
                end
                else
                begin
                    span_next = inode_span_c;
                    off_next  = idx_reg;
                    bad_next  = idx_reg == 32'd0;
                end
                ptr_next        = '0;
                chk_vld_next    = 1'b0;
                res_status_next = bba_pkg::STAT_OK;
                res_grant_next  = 1'b0;
            end
            bba_pkg::S_SCAN:
            begin
                chk_vld_next = issue && !found;
                chk_ptr_next = ptr_reg;
                if (issue)
                begin
                    ptr_next = ptr_reg + PW'(1);
                end
                if (found)
                begin
                    off_next        = (32'(chk_ptr_reg) << 5) | 32'(hit_bit);
                    res_grant_next  = 1'b1;
                    res_status_next = bba_pkg::STAT_OK;
                end
                else if (scan_done)
                begin
                    res_status_next = bba_pkg::STAT_FULL;
                end
            end
            bba_pkg::S_FREE_CHK:
            begin
                if (range_bad)
                begin
                    res_status_next = bba_pkg::STAT_RANGE;
                end
            end
            bba_pkg::S_CLEAR:
            begin
                ptr_next = ptr_reg + PW'(1);
            end
            bba_pkg::S_DONE:
            begin
                if (done_take)
                begin
                    rsp_vld_next    = 1'b1;
                    rsp_status_next = res_status_reg;
                    if (!res_grant_reg)
                    begin
                        rsp_granted_next = 32'd0;
                    end
                    else if (pool_reg == bba_pkg::POOL_DATA)
                    begin
                        rsp_granted_next = base_sum;
                    end
                    else
                    begin
                        rsp_granted_next = off_reg;
                    end
                end
            end
            default:
            begin
                ptr_next = ptr_reg;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= bba_pkg::S_INIT;
            ptr_reg     <= '0;
            chk_vld_reg <= 1'b0;
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            chk_vld_reg <= chk_vld_next;
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg         <= cmd_next;
        pool_reg        <= pool_next;
        idx_reg         <= idx_next;
        span_reg        <= span_next;
        off_reg         <= off_next;
        bad_reg         <= bad_next;
        chk_ptr_reg     <= chk_ptr_next;
        res_status_reg  <= res_status_next;
        res_grant_reg   <= res_grant_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_granted_reg <= rsp_granted_next;
    end

endmodule

// ===== design/bitmap_block_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit allocator over an inode bitmap and a data block bitmap, each held
// in a single-port memory of 32-bit words, with APB configuration.
// ----------------------------------------------------------------------------
// Sequence: alloc reads one bitmap word per cycle, pipelined against the check;
//   free checks the range, then reads and rewrites the word (no access when out
//   of range); clear writes zeros over every word of the pool before the response.
// Throughput: one transaction at a time; the next request is taken once the
//   result is in the output register.
// Reset: a clearing sweep over the words of the larger bitmap zeroes both
//   bitmaps before the first request is accepted; registers take reset values.
// ----------------------------------------------------------------------------
module bitmap_block_allocator #(
    parameter int INODE_BITS = 1024,
    parameter int DATA_BITS  = 4096
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bba_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    bba_req_if.sink                      req,
    bba_rsp_if.source                    rsp
);

    localparam int IWORDS = (INODE_BITS + 31) / 32;
    localparam int DWORDS = (DATA_BITS + 31) / 32;

    bba_pkg::cfg_t              cfg;
    bba_pkg::mem_req_t          inode_mem;
    bba_pkg::mem_req_t          data_mem;
    logic [bba_pkg::WORD_W-1:0] inode_rdata;
    logic [bba_pkg::WORD_W-1:0] data_rdata;

    // Configuration registers
    bba_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Inode bitmap
    bba_bitmap_ram #(
        .DEPTH (IWORDS)
    ) u_inode_ram (
        .clk   (clk),
        .req   (inode_mem),
        .rdata (inode_rdata)
    );

    // Data block bitmap
    bba_bitmap_ram #(
        .DEPTH (DWORDS)
    ) u_data_ram (
        .clk   (clk),
        .req   (data_mem),
        .rdata (data_rdata)
    );

    // Sequencer
    bba_ctrl #(
        .INODE_BITS (INODE_BITS),
        .DATA_BITS  (DATA_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .req         (req),
        .rsp         (rsp),
        .inode_mem   (inode_mem),
        .data_mem    (data_mem),
        .inode_rdata (inode_rdata),
        .data_rdata  (data_rdata)
    );

endmodule
